// ===== src/elap_pkg.sv =====
// Shared types and constants of the 3x3 Laplacian edge filter.
package elap_pkg;

  localparam int MaxWidth    = 1024;
  localparam int HeightLimit = 4096;
  localparam int ColW        = $clog2(MaxWidth);
  localparam int RowW        = $clog2(HeightLimit);
  localparam int PendW       = ColW + 1;
  localparam int WidthRegW   = 11;
  localparam int HeightRegW  = 13;
  localparam int ChanW       = 8;
  localparam int ClampTop    = 255;

  // item kinds carried on tuser
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // register indexes (byte address 4*index)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic            is_pix;
    logic            emit;
    logic            zero;
    logic            last;
    logic [ColW-1:0] col;
  } item_ctrl_t;

  typedef struct packed {
    logic [WidthRegW-1:0]  width;
    logic [HeightRegW-1:0] height;
    logic                  clear;
  } frame_cfg_t;

endpackage

// ===== src/edge_laplacian_3x3_top.sv =====
// Top level of the streaming 3x3 Laplacian edge filter with its register port.
//
// Takes RGB pixels in raster order at one transfer per clock and, per channel,
// gives 8*centre minus the eight neighbours, clamped to 0..255; border pixels of
// the frame come out as zero, and the bottom-right pixel carries tlast. A pixel
// transfer produces its result only once width+1 pixels are pending, so results
// trail the input by one line plus one pixel; flush items (tuser=1) drain the
// pending pixels as zeros, one per item, and a flush with nothing pending gives
// nothing. Inside, an item passes an input register (line-store read), a window
// stage (line-store write and window shift) and then the result register.
// The input side stalls only when the result register is full and tready is low.
// Writing frame_width (address 0) or frame_height (address 4) restarts the frame
// position; do so only while the block is idle. Line stores need no clearing
// after reset.
module edge_laplacian_3x3_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  input  logic        s_axis_tuser,   // action: 0 pixel, 1 flush
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic        m_axis_tlast,   // frame_last
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import elap_pkg::*;

  // configuration registers
  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic                  cfg_we;
  logic                  reg_idx;
  frame_cfg_t            frame_cfg;

  // pipeline control
  logic       accept;
  logic       out_adv, s2_adv, s1_adv;
  item_ctrl_t in_ctrl;
  logic       win_load;

  logic       s1_v_q;
  item_ctrl_t s1_ctrl_q;
  pixel_t     s1_pix_q;
  logic       s2_v_q;
  item_ctrl_t s2_ctrl_q;
  logic       out_v_q;
  pixel_t     out_pix_q;
  logic       out_last_q;

  pixel_t     line_top, line_mid, lap;

  // register port; pready tied high
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRegW'(640);
      height_q <= HeightRegW'(480);
    end else if (cfg_we) begin
      case (reg_idx)
        REG_WIDTH:  width_q  <= pwdata[WidthRegW-1:0];
        REG_HEIGHT: height_q <= pwdata[HeightRegW-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      default:    prdata = '0;
    endcase
  end

  // both registers are known, so every write restarts the position
  assign frame_cfg.width  = width_q;
  assign frame_cfg.height = height_q;
  assign frame_cfg.clear  = cfg_we;

  // stage advance: an item with no result leaves the window stage at once
  assign out_adv       = !out_v_q || m_axis_tready;
  assign s2_adv        = !s2_v_q || !s2_ctrl_q.emit || out_adv;
  assign s1_adv        = !s1_v_q || s2_adv;
  assign s_axis_tready = s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign win_load      = s1_v_q && s2_adv && s1_ctrl_q.is_pix;

  elap_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (frame_cfg),
    .accept_i (accept),
    .action_i (s_axis_tuser),
    .ctrl_o   (in_ctrl)
  );

  elap_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept && in_ctrl.is_pix),
    .rd_addr_i (in_ctrl.col),
    .wr_en_i   (win_load),
    .wr_addr_i (s1_ctrl_q.col),
    .wr_pix_i  (s1_pix_q),
    .top_o     (line_top),
    .mid_o     (line_mid)
  );

  elap_filter u_filter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (win_load),
    .top_i  (line_top),
    .mid_i  (line_mid),
    .pix_i  (s1_pix_q),
    .lap_o  (lap)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_q <= accept;
      end
      if (s2_adv) begin
        s2_v_q <= s1_v_q;
      end
      if (out_adv) begin
        out_v_q <= s2_v_q && s2_ctrl_q.emit;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctrl_q <= in_ctrl;
      s1_pix_q  <= pixel_t'(s_axis_tdata);
    end
    if (s2_adv) begin
      s2_ctrl_q <= s1_ctrl_q;
    end
    if (out_adv && s2_v_q && s2_ctrl_q.emit) begin
      out_pix_q  <= s2_ctrl_q.zero ? '0 : lap;
      out_last_q <= s2_ctrl_q.last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

  // an empty result register always frees the input side
  ap_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // the last pixel of a frame is a corner, so it must come out as zero
  ap_last_is_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == '0))
    else $error("frame_last pixel not zero");

endmodule

// ===== src/elap_seq.sv =====
// Position tracking: input column, output raster position and pending count.
module elap_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  elap_pkg::frame_cfg_t   cfg_i,
  input  logic                   accept_i,
  input  logic                   action_i,
  output elap_pkg::item_ctrl_t   ctrl_o
);
  import elap_pkg::*;

  logic [WidthRegW-1:0]  w_eff;
  logic [HeightRegW-1:0] h_eff;
  logic [ColW-1:0]       wm1;
  logic [RowW-1:0]       hm1;
  logic [ColW-1:0]       col;
  logic                  is_pix;
  logic                  emit;
  logic                  border;
  logic                  last;

  logic [ColW-1:0]  col_q, col_d;
  logic [ColW-1:0]  ox_q, ox_d;
  logic [RowW-1:0]  oy_q, oy_d;
  logic [PendW-1:0] pend_q, pend_d;

  always_comb begin
    if (cfg_i.width == '0) begin
      w_eff = WidthRegW'(1);
    end else if (cfg_i.width > WidthRegW'(MaxWidth)) begin
      w_eff = WidthRegW'(MaxWidth);
    end else begin
      w_eff = cfg_i.width;
    end
    if (cfg_i.height == '0) begin
      h_eff = HeightRegW'(1);
    end else if (cfg_i.height > HeightRegW'(HeightLimit)) begin
      h_eff = HeightRegW'(HeightLimit);
    end else begin
      h_eff = cfg_i.height;
    end
    // wraps correctly at the maximum (low bits zero minus one)
    wm1 = w_eff[ColW-1:0] - ColW'(1);
    hm1 = h_eff[RowW-1:0] - RowW'(1);

    col    = (col_q > wm1) ? '0 : col_q;
    is_pix = (action_i == ACT_PIXEL);
    emit   = is_pix ? (pend_q > PendW'(w_eff)) : (pend_q != '0);
    border = (ox_q == '0) || (oy_q == '0) || (ox_q == wm1) || (oy_q == hm1);
    last   = (ox_q == wm1) && (oy_q == hm1);

    ctrl_o.is_pix = is_pix;
    ctrl_o.emit   = emit;
    ctrl_o.zero   = !is_pix || border;
    ctrl_o.last   = last;
    ctrl_o.col    = col;

    col_d  = col_q;
    ox_d   = ox_q;
    oy_d   = oy_q;
    pend_d = pend_q;
    if (cfg_i.clear) begin
      col_d  = '0;
      ox_d   = '0;
      oy_d   = '0;
      pend_d = '0;
    end else if (accept_i) begin
      if (is_pix) begin
        col_d = (col == wm1) ? '0 : col + ColW'(1);
        if (!emit) begin
          pend_d = pend_q + PendW'(1);
        end
      end else if (emit) begin
        pend_d = pend_q - PendW'(1);
      end
      if (emit) begin
        if (ox_q >= wm1) begin
          ox_d = '0;
          oy_d = (oy_q >= hm1) ? '0 : oy_q + RowW'(1);
        end else begin
          ox_d = ox_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      ox_q   <= '0;
      oy_q   <= '0;
      pend_q <= '0;
    end else begin
      col_q  <= col_d;
      ox_q   <= ox_d;
      oy_q   <= oy_d;
      pend_q <= pend_d;
    end
  end

endmodule

// ===== src/elap_line_buf.sv =====
// Two line stores: read on input transfer, written when the pixel enters the window.
module elap_line_buf (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [elap_pkg::ColW-1:0] rd_addr_i,
  input  logic                      wr_en_i,
  input  logic [elap_pkg::ColW-1:0] wr_addr_i,
  input  elap_pkg::pixel_t          wr_pix_i,
  output elap_pkg::pixel_t          top_o,
  output elap_pkg::pixel_t          mid_o
);
  import elap_pkg::*;

  pixel_t upper_mem  [MaxWidth];
  pixel_t middle_mem [MaxWidth];
  pixel_t top_q;
  pixel_t mid_q;

  // upper line takes the old middle entry of the same column
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        // one-pixel lines: the column is rewritten on this edge, take the new entries
        top_q <= mid_q;
        mid_q <= wr_pix_i;
      end else begin
        top_q <= upper_mem[rd_addr_i];
        mid_q <= middle_mem[rd_addr_i];
      end
    end
    if (wr_en_i) begin
      upper_mem[wr_addr_i]  <= mid_q;
      middle_mem[wr_addr_i] <= wr_pix_i;
    end
  end

  assign top_o = top_q;
  assign mid_o = mid_q;

endmodule

// ===== src/elap_filter.sv =====
// 3x3 window registers and the per-channel clamped Laplacian.
module elap_filter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  elap_pkg::pixel_t top_i,
  input  elap_pkg::pixel_t mid_i,
  input  elap_pkg::pixel_t pix_i,
  output elap_pkg::pixel_t lap_o
);
  import elap_pkg::*;

  pixel_t win_q [9];
  pixel_t win_d [9];
  logic [8:0][ChanW-1:0] red_v, green_v, blue_v;

  function automatic logic [ChanW-1:0] lap_chan(input logic [8:0][ChanW-1:0] v);
    logic [ChanW+2:0]        sum;
    logic signed [ChanW+4:0] diff;
    sum = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        sum = sum + (ChanW+3)'(v[k]);
      end
    end
    diff = $signed({2'b00, v[4], 3'b000}) - $signed({2'b00, sum});
    if (diff < 0) begin
      return '0;
    end else if (diff > $signed((ChanW+5)'(ClampTop))) begin
      return ChanW'(ClampTop);
    end else begin
      return diff[ChanW-1:0];
    end
  endfunction

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3+0] = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = top_i;
    win_d[5] = mid_i;
    win_d[8] = pix_i;
    for (int k = 0; k < 9; k++) begin
      red_v[k]   = win_q[k].red;
      green_v[k] = win_q[k].green;
      blue_v[k]  = win_q[k].blue;
    end
    lap_o.red   = lap_chan(red_v);
    lap_o.green = lap_chan(green_v);
    lap_o.blue  = lap_chan(blue_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (load_i) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= win_d[k];
      end
    end
  end

endmodule
